// File: design/bphg_pkg.sv
// ----------------------------------------------------------------------------
// bphg_pkg
// Types, register codes and timer helpers shared by the press/hold qualifier.
// ----------------------------------------------------------------------------
package bphg_pkg;

	localparam int TIMER_BITS = 16;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STIM     = 2'd2;

	localparam logic [9:0]  DEBOUNCE_RESET = 10'd15;
	localparam logic [15:0] HOLD_RESET     = 16'd600;
	localparam logic [15:0] STIM_RESET     = 16'd1000;

	typedef struct packed {
		logic kind;
		logic level;
	} in_item_t;

	typedef struct packed {
		logic press;
		logic hold;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  debounce_ticks;
		logic [15:0] hold_ticks;
		logic [15:0] stim_interval_ms;
	} cfg_regs_t;

	// zero loads as one, large values saturate at the timer's full scale
	function automatic logic [TIMER_BITS-1:0] timer_load(input logic [15:0] v);
		logic [32:0] maxv;
		logic [32:0] ext;
		begin
			maxv = (33'd1 << TIMER_BITS) - 33'd1;
			ext  = {17'd0, v};
			if (v == 16'd0) begin
				timer_load = TIMER_BITS'(1);
			end else if (ext > maxv) begin
				timer_load = maxv[TIMER_BITS-1:0];
			end else begin
				timer_load = ext[TIMER_BITS-1:0];
			end
		end
	endfunction

endpackage

// File: design/bphg_cfg.sv
// ----------------------------------------------------------------------------
// bphg_cfg
// Configuration register file: debounce, hold threshold, stimulus period.
// ----------------------------------------------------------------------------
module bphg_cfg import bphg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_regs_t                regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ticks   <= DEBOUNCE_RESET;
			regs_q.hold_ticks       <= HOLD_RESET;
			regs_q.stim_interval_ms <= STIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE: regs_q.debounce_ticks   <= cfg_data[9:0];
				CFG_HOLD:     regs_q.hold_ticks       <= cfg_data;
				CFG_STIM:     regs_q.stim_interval_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// File: design/bphg_core.sv
// ----------------------------------------------------------------------------
// bphg_core
// Gesture state machine, wait timer and stimulus counter; one update per item.
// ----------------------------------------------------------------------------
module bphg_core import bphg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_regs_t regs,
	output logic      res_valid,
	output out_item_t res
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_DEBOUNCE = 2'd1;
	localparam logic [1:0] ST_DOWN     = 2'd2;
	localparam logic [1:0] ST_HELD     = 2'd3;

	logic [1:0]            state_q, state_d;
	logic                  pin_q, pin_d;
	logic [TIMER_BITS-1:0] wait_q, wait_d;
	logic                  armed_q, armed_d;
	logic [TIMER_BITS-1:0] stim_q, stim_d;
	logic                  press, hold;

	logic [TIMER_BITS-1:0] deb_load;
	logic [15:0]           deb_ext;
	logic [15:0]           rem;

	always_comb begin
		deb_ext  = {6'd0, regs.debounce_ticks};
		deb_load = timer_load(deb_ext);
		// hold wait covers the part of the threshold left after debounce
		if ({16'd0, regs.hold_ticks} > 32'(deb_load)) begin
			rem = regs.hold_ticks - 16'(deb_load);
		end else begin
			rem = 16'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		pin_d   = pin_q;
		wait_d  = wait_q;
		armed_d = armed_q;
		stim_d  = stim_q;
		press   = 1'b0;
		hold    = 1'b0;
		if (item.kind) begin
			pin_d = item.level;
			unique case (state_q)
				ST_IDLE: begin
					if (item.level) begin
						state_d = ST_DEBOUNCE;
						wait_d  = deb_load;
						armed_d = 1'b1;
					end
				end
				ST_DOWN: begin
					if (!item.level) begin
						armed_d = 1'b0;
						wait_d  = '0;
						press   = 1'b1;
						state_d = ST_IDLE;
					end
				end
				ST_HELD: begin
					if (!item.level) begin
						state_d = ST_IDLE;
					end
				end
				default: ;
			endcase
		end else begin
			if (armed_q) begin
				if (wait_q <= TIMER_BITS'(1)) begin
					wait_d  = '0;
					armed_d = 1'b0;
					if (state_q == ST_DEBOUNCE) begin
						// re-check the pin at the end of debounce
						if (!pin_q) begin
							state_d = ST_IDLE;
						end else begin
							state_d = ST_DOWN;
							wait_d  = timer_load(rem);
							armed_d = 1'b1;
						end
					end else if (state_q == ST_DOWN) begin
						state_d = ST_HELD;
						hold    = 1'b1;
					end
				end else begin
					wait_d = wait_q - TIMER_BITS'(1);
				end
			end
			if (stim_q <= TIMER_BITS'(1)) begin
				press  = 1'b1;
				stim_d = timer_load(regs.stim_interval_ms);
			end else begin
				stim_d = stim_q - TIMER_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pin_q   <= 1'b0;
			wait_q  <= '0;
			armed_q <= 1'b0;
			stim_q  <= timer_load(STIM_RESET);
		end else if (step) begin
			state_q <= state_d;
			pin_q   <= pin_d;
			wait_q  <= wait_d;
			armed_q <= armed_d;
			stim_q  <= stim_d;
		end
	end

	assign res_valid = step && (press || hold);
	assign res.press = press;
	assign res.hold  = hold;

endmodule

// File: design/bphg_obuf.sv
// ----------------------------------------------------------------------------
// bphg_obuf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
module bphg_obuf import bphg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [1:0] cnt_q;
	out_item_t  head_q;
	out_item_t  tail_q;
	logic       pop;

	assign pop       = (cnt_q != 2'd0) && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= push_data;
				end else begin
					tail_q <= push_data;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			default: ;
		endcase
	end

endmodule

// File: design/button_press_hold_gesture.sv
// ----------------------------------------------------------------------------
// button_press_hold_gesture
// Debounced button qualifier producing PRESS and HOLD gestures.
// ----------------------------------------------------------------------------
// Items (ticks or pin edges) are registered on input, then the gesture state,
// wait timer and stimulus counter are updated in a single cycle as the item
// leaves the input register. An item that produces PRESS and/or HOLD pushes one
// result into a two-entry output buffer. One item per clock is sustained while
// the result side keeps up. Only a full output buffer holds back new input.
// Configuration writes apply at the next load of the wait timer or stimulus
// counter.
module button_press_hold_gesture import bphg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      full;
	logic      step;
	logic      res_valid;
	out_item_t res;
	cfg_regs_t regs;
	logic      in_fire;

	// the input register drains whenever the result buffer has room
	assign step     = valid_s1 && !full;
	assign in_stall = valid_s1 && full;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	bphg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	bphg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.regs      (regs),
		.res_valid (res_valid),
		.res       (res)
	);

	bphg_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: dv/gesture_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_scoreboard_pkg
// Press/hold predictor and in-order result scoreboard for the gesture bench.
// ----------------------------------------------------------------------------
package gesture_scoreboard_pkg;
	import bphg_pkg::*;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_EDGE = 1'b1;

	// index with no register behind it, writes must be dropped
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

	typedef enum logic [1:0] {
		G_IDLE,
		G_DEBOUNCE,
		G_DOWN,
		G_HELD
	} gesture_e;

	class gesture_scoreboard;
		gesture_e    state;
		bit          pin;
		bit [15:0]   wait_cnt;
		bit          armed;
		bit [15:0]   stim_cnt;
		bit [9:0]    debounce;
		bit [15:0]   hold_thr;
		bit [15:0]   stim_int;
		out_item_t   gestures_q[$];
		int unsigned errors;

		function new();
			debounce = DEBOUNCE_RESET;
			hold_thr = HOLD_RESET;
			stim_int = STIM_RESET;
			state    = G_IDLE;
			pin      = 1'b0;
			wait_cnt = '0;
			armed    = 1'b0;
			stim_cnt = timer_value(STIM_RESET);
			errors   = 0;
		endfunction

		// zero counts as one; a 16-bit value never exceeds the 16-bit timer
		function bit [15:0] timer_value(bit [15:0] v);
			return (v == 16'd0) ? 16'd1 : v;
		endfunction

		function int pending();
			return gestures_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			case (idx)
				CFG_DEBOUNCE: debounce = value[9:0];
				CFG_HOLD:     hold_thr = value;
				CFG_STIM:     stim_int = value;
				default: ;
			endcase
		endfunction

		function void note_input(in_item_t item);
			bit        press;
			bit        hold;
			bit [15:0] deb;
			out_item_t res;
			press = 1'b0;
			hold  = 1'b0;
			if (item.kind == KIND_EDGE) begin
				pin = item.level;
				case (state)
					G_IDLE: if (item.level) begin
						state    = G_DEBOUNCE;
						wait_cnt = timer_value({6'd0, debounce});
						armed    = 1'b1;
					end
					G_DOWN: if (!item.level) begin
						armed    = 1'b0;
						wait_cnt = '0;
						press    = 1'b1;
						state    = G_IDLE;
					end
					G_HELD: if (!item.level) begin
						state = G_IDLE;
					end
					default: ;
				endcase
			end else begin
				if (armed) begin
					if (wait_cnt <= 16'd1) begin
						wait_cnt = '0;
						armed    = 1'b0;
						case (state)
							G_DEBOUNCE: if (!pin) begin
								state = G_IDLE;
							end else begin
								// hold wait is whatever is left of the threshold, at least one tick
								deb      = timer_value({6'd0, debounce});
								state    = G_DOWN;
								wait_cnt = timer_value((hold_thr > deb) ? hold_thr - deb : 16'd1);
								armed    = 1'b1;
							end
							G_DOWN: begin
								state = G_HELD;
								hold  = 1'b1;
							end
							default: ;
						endcase
					end else begin
						wait_cnt--;
					end
				end
				if (stim_cnt <= 16'd1) begin
					press    = 1'b1;
					stim_cnt = timer_value(stim_int);
				end else begin
					stim_cnt--;
				end
			end
			if (press || hold) begin
				res.press = press;
				res.hold  = hold;
				gestures_q.push_back(res);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (gestures_q.size() == 0) begin
				$error("unexpected gesture: press=%0b hold=%0b", got.press, got.hold);
				errors++;
				return;
			end
			exp_item = gestures_q.pop_front();
			if (got.press !== exp_item.press) begin
				$error("press: expected %0b, got %0b", exp_item.press, got.press);
				errors++;
			end
			if (got.hold !== exp_item.hold) begin
				$error("hold: expected %0b, got %0b", exp_item.hold, got.hold);
				errors++;
			end
		endfunction
	endclass

endpackage

// File: dv/button_press_hold_gesture_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_hold_gesture_tb
// Drives tick and pin-edge transfers into the press/hold qualifier under
// random gaps and output stalls, predicts every PRESS/HOLD gesture and checks
// each result transfer in order, across several register settings.
// ----------------------------------------------------------------------------
module button_press_hold_gesture_tb;
	import bphg_pkg::*;
	import gesture_scoreboard_pkg::*;

	localparam int N_PHASES      = 6;
	localparam int N_DIRECTED    = 25;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLDOFF_LEN   = 150;
	localparam int MAX_RUN       = 40;

	localparam in_item_t TICK    = '{kind: KIND_TICK, level: 1'b0};
	localparam in_item_t TICK_HI = '{kind: KIND_TICK, level: 1'b1};
	localparam in_item_t PUSH    = '{kind: KIND_EDGE, level: 1'b1};
	localparam in_item_t LIFT    = '{kind: KIND_EDGE, level: 1'b0};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	gesture_scoreboard sb;
	int unsigned       items_sent;
	bit                send_fast;
	bit                recv_fast;
	bit                holdoff_due;

	button_press_hold_gesture u_dut (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("button_press_hold_gesture_tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_input(in_data);
		end
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
	end

	// result side: random stall before each transfer, one long hold-off per phase
	initial begin : receiver
		int unsigned pause;
		int unsigned served;
		out_stall = 1'b0;
		served    = 0;
		forever begin
			if (served % 40 == 0) begin
				recv_fast = ($urandom_range(0, 2) == 0);
			end
			if (holdoff_due) begin
				holdoff_due = 1'b0;
				pause       = HOLDOFF_LEN;
			end else if (recv_fast) begin
				pause = 0;
			end else begin
				pause = $urandom_range(0, 13);
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(arst_n && out_valid && !out_stall));
			@(negedge clk);
			served++;
		end
	end

	function automatic in_item_t edge_item(input logic level);
		return '{kind: KIND_EDGE, level: level};
	endfunction

	function automatic in_item_t tick_item();
		return '{kind: KIND_TICK, level: 1'($urandom)};
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input in_item_t item);
		int unsigned gap;
		gap = send_fast ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
		if (items_sent % 32 == 0) begin
			send_fast = ($urandom_range(0, 2) == 0);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic apply_config(input cfg_regs_t regs, input bit touch_spare);
		// junk in the bits above the debounce field must be dropped
		write_reg(CFG_DEBOUNCE, {6'($urandom), regs.debounce_ticks});
		write_reg(CFG_HOLD, regs.hold_ticks);
		write_reg(CFG_STIM, regs.stim_interval_ms);
		if (touch_spare) begin
			write_reg(CFG_SPARE, 16'($urandom));
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly press/hold/release sequences with random length, some noise
	task automatic run_random(input cfg_regs_t regs, input int unsigned n);
		int unsigned stop_at;
		int unsigned reach;
		int unsigned run_len;
		stop_at = items_sent + n;
		reach   = ((regs.debounce_ticks == 0) ? 1 : regs.debounce_ticks) + regs.hold_ticks + 3;
		if (reach > MAX_RUN) begin
			reach = MAX_RUN;
		end
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				send_item(edge_item(1'b1));
				if ($urandom_range(0, 4) == 0) begin
					send_item(edge_item(1'b0));
					send_item(edge_item(1'b1));
				end
				run_len = $urandom_range(0, reach);
				repeat (run_len) send_item(tick_item());
				send_item(edge_item(1'b0));
				repeat ($urandom_range(0, 3)) send_item(tick_item());
			end else begin
				repeat ($urandom_range(1, 6)) send_item(in_item_t'(2'($urandom)));
			end
		end
	endtask

	initial begin : stimulus
		cfg_regs_t   phase_cfg [N_PHASES];
		int unsigned phase_items [N_PHASES];
		in_item_t    directed [N_DIRECTED];
		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_DEBOUNCE;
		cfg_data    = '0;
		items_sent  = 0;
		send_fast   = 1'b0;
		holdoff_due = 1'b0;

		// press to hold, bounces, release while idle, debounce ending released
		directed = '{TICK, PUSH, TICK, TICK, PUSH, TICK, TICK, TICK, LIFT, LIFT,
			PUSH, TICK, TICK, LIFT, PUSH, LIFT, TICK, TICK, PUSH, LIFT,
			PUSH, TICK, TICK, TICK_HI, TICK};

		phase_cfg[0] = '{debounce_ticks: 10'd1,    hold_ticks: 16'd2,     stim_interval_ms: 16'd1};
		phase_cfg[1] = '{debounce_ticks: 10'd0,    hold_ticks: 16'd0,     stim_interval_ms: 16'd0};
		phase_cfg[2] = '{debounce_ticks: 10'd3,    hold_ticks: 16'd10,    stim_interval_ms: 16'd17};
		phase_cfg[3] = '{debounce_ticks: 10'd4,    hold_ticks: 16'd4,     stim_interval_ms: 16'd1};
		phase_cfg[4] = '{debounce_ticks: 10'd2,    hold_ticks: 16'd12,    stim_interval_ms: 16'd9};
		phase_cfg[5] = '{debounce_ticks: 10'd1023, hold_ticks: 16'd65535, stim_interval_ms: 16'd65535};
		phase_items  = '{300, 300, 300, 300, 300, 100};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		apply_config('{debounce_ticks: 10'd2, hold_ticks: 16'd4, stim_interval_ms: 16'd6}, 1'b0);
		foreach (directed[i]) begin
			send_item(directed[i]);
		end
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			apply_config(phase_cfg[p], p == 2);
			holdoff_due = 1'b1;
			run_random(phase_cfg[p], phase_items[p]);
			drain();
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("button_press_hold_gesture_tb OK");
		end else begin
			$display("button_press_hold_gesture_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: button_press_hold_gesture.f
design/bphg_pkg.sv
design/bphg_cfg.sv
design/bphg_core.sv
design/bphg_obuf.sv
design/button_press_hold_gesture.sv
dv/gesture_scoreboard_pkg.sv
dv/button_press_hold_gesture_tb.sv
